// ===== rtl/epx_pkg.sv =====
// shared types and constants for the epx scale2x stream block
// no dependencies; imported by epx_kernel and epx_scale2x_stream
package epx_pkg;

  // default maximum row length in pixels
  localparam int unsigned MaxWidthDef = 2048;

  // fixed field widths
  localparam int unsigned PixW     = 32;
  localparam int unsigned ColW     = 11;
  localparam int unsigned RowW     = 16;
  localparam int unsigned CfgW     = 12;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned OutDataW = 160;

  // input word kinds carried on tuser
  typedef enum logic {
    CMD_PIXEL = 1'b0,
    CMD_DRAIN = 1'b1
  } epx_cmd_e;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_WIDTH = 1'b0,
    REG_MODE  = 1'b1
  } epx_reg_e;

  // pixel compare modes
  typedef enum logic {
    MODE_BYTE = 1'b0,
    MODE_RGBA = 1'b1
  } epx_mode_e;

  // control flags of one word in the compute stage
  typedef struct packed {
    logic            emit;      // a finished row is pending, produce a block
    logic            drain;     // drain word, down neighbour is the center
    logic            last;      // last column of the row
    logic            first_col; // column zero, left neighbour is the center
    logic            up_zero;   // output row zero, up neighbour is the center
    logic            use_fwd;   // upper line entry still in flight, take bypass
    logic [ColW-1:0] src_col;
    logic [RowW-1:0] src_row;
  } epx_ctl_t;

endpackage

// ===== rtl/epx_ram.sv =====
// generic single write, single read memory with registered read data
// no dependencies
module epx_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // read first: a read at the written address returns the old entry
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/epx_kernel.sv =====
// epx quadrant selection, left neighbour hold and output register
// depends on epx_pkg
module epx_kernel (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         mode_i,
  input  logic                         s1_valid_i,
  input  epx_pkg::epx_ctl_t            ctl_i,
  input  logic [epx_pkg::PixW-1:0]     pix_i,
  input  logic [epx_pkg::PixW-1:0]     mid_c_i,
  input  logic [epx_pkg::PixW-1:0]     mid_r_i,
  input  logic [epx_pkg::PixW-1:0]     up_i,
  input  logic [epx_pkg::PixW-1:0]     fwd_i,
  output logic                         adv_o,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // top_left, top_right, bottom_left, bottom_right, src_col, src_row, zero pad
  output logic [epx_pkg::OutDataW-1:0] m_axis_tdata
);
  import epx_pkg::*;

  logic [PixW-1:0]     left_q;
  logic [PixW-1:0]     mask;
  logic [PixW-1:0]     c, u, r, l, d;
  logic                lu, ur, rd, dl;
  logic [PixW-1:0]     tl, tr, bl, br;
  logic                slot_free;
  logic                out_valid_q, out_valid_d;
  logic [OutDataW-1:0] out_data_q;

  // neighbour window with border replication
  always_comb begin
    mask = (epx_mode_e'(mode_i) == MODE_RGBA) ? {PixW{1'b1}} : PixW'(8'hFF);
    c = mid_c_i & mask;
    u = (ctl_i.up_zero ? mid_c_i : (ctl_i.use_fwd ? fwd_i : up_i)) & mask;
    r = (ctl_i.last ? mid_c_i : mid_r_i) & mask;
    l = (ctl_i.first_col ? mid_c_i : left_q) & mask;
    d = (ctl_i.drain ? mid_c_i : pix_i) & mask;
  end

  // epx equalities and quadrant pick
  always_comb begin
    lu = (l == u);
    ur = (u == r);
    rd = (r == d);
    dl = (d == l);
    tl = (lu && !dl && !ur) ? u : c;
    tr = (ur && !lu && !rd) ? r : c;
    bl = (dl && !rd && !lu) ? l : c;
    br = (rd && !ur && !dl) ? d : c;
  end

  // stage advance and output word handshake
  always_comb begin
    slot_free   = !out_valid_q || m_axis_tready;
    adv_o       = s1_valid_i && (!ctl_i.emit || slot_free);
    out_valid_d = out_valid_q;
    if (adv_o && ctl_i.emit) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // output payload and left neighbour hold
  always_ff @(posedge clk_i) begin
    if (adv_o && ctl_i.emit) begin
      out_data_q <= {5'b0, ctl_i.src_row, ctl_i.src_col, br, bl, tr, tl};
    end
    if (adv_o) begin
      left_q <= mid_c_i;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

// ===== rtl/epx_scale2x_stream.sv =====
// epx scale2x stream: one source word in per cycle, one 2x2 block out per cycle while m_axis does not stall
// a completing word passes the compute stage registers, then the output register, before its block leaves on m_axis
// throughput: one word per cycle while m_axis does not stall, bound by the single write port of each line memory
// reset clears column, row and pending-row state, sets width 1 and byte mode;
// the line memories keep their contents, no clearing pass is run
// depends on epx_pkg, epx_ram, epx_kernel
module epx_scale2x_stream #(
  parameter int unsigned MAX_WIDTH = epx_pkg::MaxWidthDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration write port
  input  logic                         cfg_we_i,
  input  logic [epx_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [epx_pkg::CfgW-1:0]     cfg_wdata_i,
  // source words
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // pixel
  input  logic [epx_pkg::PixW-1:0]     s_axis_tdata,
  // cmd
  input  logic                         s_axis_tuser,
  // result words
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // top_left, top_right, bottom_left, bottom_right, src_col, src_row, zero pad
  output logic [epx_pkg::OutDataW-1:0] m_axis_tdata
);
  import epx_pkg::*;

  localparam int unsigned AW = $clog2(MAX_WIDTH);
  localparam int unsigned CW = (AW + 1 > CfgW) ? AW + 1 : CfgW;

  // configuration
  logic [CfgW-1:0] width_q;
  logic            mode_q;

  // stream position
  logic [AW-1:0]   col_q, col_d;
  logic [RowW-1:0] row_q, row_d;
  logic            pend_q, pend_d;

  // compute stage
  logic            s1_valid_q, s1_valid_d;
  epx_ctl_t        s1_ctl_q;
  logic [PixW-1:0] s1_pix_q;
  logic [AW-1:0]   s1_x_q;
  logic [PixW-1:0] fwd_q;

  logic [CW-1:0]   w_ext, w_eff, x_inc;
  logic            last;
  logic [AW-1:0]   x_plus;
  logic            in_acc, is_drain, take, adv;
  logic            use_fwd;
  logic [PixW-1:0] mid_c, mid_r, up_rd;
  epx_ctl_t        ctl_new;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= CfgW'(1);
      mode_q  <= MODE_BYTE;
    end else if (cfg_we_i) begin
      unique case (epx_reg_e'(cfg_idx_i))
        REG_WIDTH: width_q <= cfg_wdata_i;
        REG_MODE:  mode_q  <= cfg_wdata_i[0];
        default:   ;
      endcase
    end
  end

  // effective width and end of row
  always_comb begin
    w_ext = CW'(width_q);
    priority if (w_ext == '0) begin
      w_eff = CW'(1);
    end else if (w_ext > CW'(MAX_WIDTH)) begin
      w_eff = CW'(MAX_WIDTH);
    end else begin
      w_eff = w_ext;
    end
    x_inc  = CW'(col_q) + CW'(1);
    last   = (x_inc >= w_eff);
    x_plus = AW'(x_inc);
  end

  // input acceptance; a drain with no pending row is dropped
  assign s_axis_tready = !s1_valid_q || adv;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign is_drain      = (epx_cmd_e'(s_axis_tuser) == CMD_DRAIN);
  assign take          = in_acc && !(is_drain && !pend_q);

  // upper line entry written by the word leaving the stage in this cycle
  assign use_fwd = s1_valid_q && !s1_ctl_q.drain && (s1_x_q == col_q);

  always_comb begin
    ctl_new.emit      = pend_q;
    ctl_new.drain     = is_drain;
    ctl_new.last      = last;
    ctl_new.first_col = (col_q == '0);
    ctl_new.up_zero   = (row_q == RowW'(1));
    ctl_new.use_fwd   = use_fwd;
    ctl_new.src_col   = ColW'(col_q);
    ctl_new.src_row   = row_q - RowW'(1);
  end

  // column, row and pending-row update
  always_comb begin
    col_d  = col_q;
    row_d  = row_q;
    pend_d = pend_q;
    if (take) begin
      if (last) begin
        col_d = '0;
        if (!is_drain) begin
          row_d  = row_q + RowW'(1);
          pend_d = 1'b1;
        end else begin
          row_d  = '0;
          pend_d = 1'b0;
        end
      end else begin
        col_d = x_plus;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      pend_q <= 1'b0;
    end else begin
      col_q  <= col_d;
      row_q  <= row_d;
      pend_q <= pend_d;
    end
  end

  // compute stage occupancy
  always_comb begin
    s1_valid_d = s1_valid_q;
    if (take) begin
      s1_valid_d = 1'b1;
    end else if (adv) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  // compute stage payload and upper line bypass
  always_ff @(posedge clk_i) begin
    if (take) begin
      s1_ctl_q <= ctl_new;
      s1_pix_q <= s_axis_tdata;
      s1_x_q   <= col_q;
      fwd_q    <= mid_c;
    end
  end

  // middle line, center read port; pixel written at accept
  epx_ram #(
    .WIDTH (PixW),
    .DEPTH (MAX_WIDTH)
  ) u_mid_c (
    .clk_i   (clk_i),
    .we_i    (take && !is_drain),
    .waddr_i (col_q),
    .wdata_i (s_axis_tdata),
    .re_i    (take),
    .raddr_i (col_q),
    .rdata_o (mid_c)
  );

  // middle line copy for the right neighbour read
  epx_ram #(
    .WIDTH (PixW),
    .DEPTH (MAX_WIDTH)
  ) u_mid_r (
    .clk_i   (clk_i),
    .we_i    (take && !is_drain),
    .waddr_i (col_q),
    .wdata_i (s_axis_tdata),
    .re_i    (take),
    .raddr_i (x_plus),
    .rdata_o (mid_r)
  );

  // upper line, takes the old middle entry when the word leaves the stage
  epx_ram #(
    .WIDTH (PixW),
    .DEPTH (MAX_WIDTH)
  ) u_upper (
    .clk_i   (clk_i),
    .we_i    (adv && !s1_ctl_q.drain),
    .waddr_i (s1_x_q),
    .wdata_i (mid_c),
    .re_i    (take),
    .raddr_i (col_q),
    .rdata_o (up_rd)
  );

  // quadrant logic and output register
  epx_kernel u_kernel (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .mode_i        (mode_q),
    .s1_valid_i    (s1_valid_q),
    .ctl_i         (s1_ctl_q),
    .pix_i         (s1_pix_q),
    .mid_c_i       (mid_c),
    .mid_r_i       (mid_r),
    .up_i          (up_rd),
    .fwd_i         (fwd_q),
    .adv_o         (adv),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // a drain with no pending row leaves the stage empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && is_drain && !pend_q && !s1_valid_q |=> !s1_valid_q)
    else $error("dropped drain word entered the compute stage");

  // column position stays inside the line memories
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    CW'(col_q) < CW'(MAX_WIDTH))
    else $error("column position beyond line memory depth");

  // a drain of the last column ends the frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && is_drain && pend_q && last |=> !pend_q && col_q == '0 && row_q == '0)
    else $error("final drain did not return to frame start");

  // a held compute stage blocks new words
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !adv |-> !s_axis_tready)
    else $error("word accepted while the compute stage is held");

  // bypass only for the entry written by the departing word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && use_fwd |-> adv && !s1_ctl_q.drain)
    else $error("upper line bypass without a matching write");

endmodule

// ===== test/tb_epx_scale2x_stream.sv =====
// self-checking testbench for epx_scale2x_stream: predicts every 2x2 output block
// from the accepted source words and checks the m_axis words in order
// depends on epx_pkg and the epx_scale2x_stream rtl
`timescale 1ns / 1ps

module tb_epx_scale2x_stream;
  import epx_pkg::*;

  localparam int unsigned LineDepth = MaxWidthDef;

  // one output block, last field in the lowest bits as on m_axis_tdata
  typedef struct packed {
    logic [RowW-1:0] src_row;
    logic [ColW-1:0] src_col;
    logic [PixW-1:0] bottom_right;
    logic [PixW-1:0] bottom_left;
    logic [PixW-1:0] top_right;
    logic [PixW-1:0] top_left;
  } epx_block_t;

  localparam int unsigned BlockW = $bits(epx_block_t);

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 cfg_we_i      = 1'b0;
  logic [CfgIdxW-1:0]   cfg_idx_i     = '0;
  logic [CfgW-1:0]      cfg_wdata_i   = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [PixW-1:0]      s_axis_tdata  = '0;  // pixel
  logic                 s_axis_tuser  = 1'b0; // cmd
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  // top_left, top_right, bottom_left, bottom_right, src_col, src_row, zero pad
  logic [OutDataW-1:0]  m_axis_tdata;

  epx_scale2x_stream dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #1 clk_i = ~clk_i;

  // scaler state mirror
  logic [PixW-1:0] upper_mem  [LineDepth];
  logic [PixW-1:0] middle_mem [LineDepth];
  int unsigned     col_idx     = 0;
  logic [RowW-1:0] row_idx     = '0;
  bit              row_pending = 1'b0;
  logic [PixW-1:0] left_pix    = '0;
  logic [CfgW-1:0] width_cfg   = 12'd1;
  epx_mode_e       mode_cfg    = MODE_BYTE;

  epx_block_t blocks_due[$];
  epx_block_t got_blk;
  int unsigned mismatches = 0;
  int unsigned words_sent = 0;
  bit idle_en = 1'b1;
  int unsigned stall_left = 0;

  // small per-frame palettes so neighbours often compare equal
  logic [23:0] hi_pal [2];
  logic [7:0]  lo_pal [3];

  function automatic int unsigned active_width();
    if (width_cfg == '0) return 1;
    if (width_cfg > LineDepth) return LineDepth;
    return width_cfg;
  endfunction

  // advance the mirror by one accepted word, queue the block it completes
  function automatic void scale_word(epx_cmd_e cmd, logic [PixW-1:0] pix);
    int unsigned w, x;
    logic [RowW-1:0] orow;
    logic [PixW-1:0] msk, c, u, r, l, d;
    bit last, lu, ur, rd, dl;
    epx_block_t blk;
    w = active_width();
    x = (col_idx >= LineDepth) ? 0 : col_idx;
    last = (x + 1 >= w);
    orow = row_idx - 16'd1;
    if (cmd == CMD_DRAIN && !row_pending) return;
    if (row_pending) begin
      msk = (mode_cfg == MODE_RGBA) ? 32'hFFFF_FFFF : 32'h0000_00FF;
      c = middle_mem[x] & msk;
      u = (orow == '0) ? c : (upper_mem[x] & msk);
      r = last ? c : (middle_mem[x + 1] & msk);
      l = (x == 0) ? c : (left_pix & msk);
      d = (cmd == CMD_DRAIN) ? c : (pix & msk);
      lu = (l == u);
      ur = (u == r);
      rd = (r == d);
      dl = (d == l);
      blk.top_left     = (lu && !dl && !ur) ? u : c;
      blk.top_right    = (ur && !lu && !rd) ? r : c;
      blk.bottom_left  = (dl && !rd && !lu) ? l : c;
      blk.bottom_right = (rd && !ur && !dl) ? d : c;
      blk.src_col      = ColW'(x);
      blk.src_row      = orow;
      blocks_due.push_back(blk);
    end
    left_pix = middle_mem[x];
    if (cmd == CMD_PIXEL) begin
      upper_mem[x]  = middle_mem[x];
      middle_mem[x] = pix;
    end
    if (last) begin
      col_idx = 0;
      if (cmd == CMD_PIXEL) begin
        row_idx     = row_idx + 16'd1;
        row_pending = 1'b1;
      end else begin
        row_idx     = '0;
        row_pending = 1'b0;
      end
    end else begin
      col_idx = x + 1;
    end
  endfunction

  function automatic void refresh_palette();
    hi_pal[0] = 24'($urandom);
    hi_pal[1] = 24'($urandom);
    for (int i = 0; i < 3; i++) lo_pal[i] = 8'($urandom);
  endfunction

  function automatic logic [PixW-1:0] pick_pixel();
    if ($urandom_range(0, 9) == 0) return $urandom;
    return {hi_pal[$urandom_range(0, 1)], lo_pal[$urandom_range(0, 2)]};
  endfunction

  // receiver: random stall bursts while idle_en is set
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left    <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (idle_en && $urandom_range(0, 7) == 0) begin
      stall_left    <= $urandom_range(0, 9);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  task automatic check_block(epx_block_t want, epx_block_t got, logic [OutDataW-BlockW-1:0] pad);
    string bad;
    bad = "";
    if (got.top_left !== want.top_left) bad = {bad, " top_left"};
    if (got.top_right !== want.top_right) bad = {bad, " top_right"};
    if (got.bottom_left !== want.bottom_left) bad = {bad, " bottom_left"};
    if (got.bottom_right !== want.bottom_right) bad = {bad, " bottom_right"};
    if (got.src_col !== want.src_col) bad = {bad, " src_col"};
    if (got.src_row !== want.src_row) bad = {bad, " src_row"};
    if (pad !== '0) bad = {bad, " pad"};
    if (bad != "") begin
      if (mismatches < 10)
        $display("block col %0d row %0d, wrong:%s expected %h got %h",
                 want.src_col, want.src_row, bad, want, got);
      mismatches++;
    end
  endtask

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_blk = m_axis_tdata[BlockW-1:0];
      if (blocks_due.size() == 0) begin
        if (mismatches < 10) $display("unexpected block %h", got_blk);
        mismatches++;
      end else begin
        check_block(blocks_due.pop_front(), got_blk, m_axis_tdata[OutDataW-1:BlockW]);
      end
    end
  end

  // present one word, hold it until accepted, then update the mirror
  task automatic send_word(epx_cmd_e cmd, logic [PixW-1:0] pix);
    if (idle_en && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= pix;
    s_axis_tuser  <= cmd;
    do @(posedge clk_i); while (!s_axis_tready);
    scale_word(cmd, pix);
    words_sent++;
  endtask

  // drain word inside a frame; a pixel instead where the skipped upper line
  // update would leave an entry behind that was never filled
  task automatic send_stray_drain();
    if (row_pending && $isunknown(upper_mem[col_idx]))
      send_word(CMD_PIXEL, pick_pixel());
    else
      send_word(CMD_DRAIN, $urandom);
  endtask

  // stop sending and let every expected block come out
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (blocks_due.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(epx_reg_e idx, logic [CfgW-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_WIDTH) width_cfg = val;
    else mode_cfg = epx_mode_e'(val[0]);
    @(posedge clk_i);
  endtask

  // complete the current row, then drain the pending one
  task automatic finish_frame();
    while (row_pending || col_idx != 0)
      send_word(row_pending ? CMD_DRAIN : CMD_PIXEL, pick_pixel());
  endtask

  // reset values: width 1, byte mode, drain with nothing pending
  task automatic test_reset_defaults();
    send_word(CMD_DRAIN, 32'hFFFF_FFFF);
    send_word(CMD_PIXEL, 32'hA5A5_A55A);
    send_word(CMD_PIXEL, 32'h5A5A_5AA5);
    send_word(CMD_DRAIN, 32'h0000_0000);
  endtask

  // width zero behaves as one
  task automatic test_width_zero();
    wait_idle();
    write_reg(REG_WIDTH, 12'd0);
    send_word(CMD_PIXEL, 32'h0000_0011);
    send_word(CMD_PIXEL, 32'hFFFF_FF22);
    send_word(CMD_DRAIN, 32'h1234_5678);
  endtask

  // byte mode, only the low byte compares
  task automatic test_byte_mode();
    logic [7:0] lo [9] = '{8'h00, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00};
    wait_idle();
    write_reg(REG_WIDTH, 12'd3);
    write_reg(REG_MODE, {11'h7FF, MODE_BYTE});
    for (int i = 0; i < 9; i++)
      send_word(CMD_PIXEL, (i == 2) ? 32'hFFFF_FFFF : {24'($urandom), lo[i]});
    finish_frame();
  endtask

  // rgba mode with equal low bytes, then drains in the middle of a row
  task automatic test_rgba_drain_mid_row();
    logic [PixW-1:0] pat [7] = '{32'h1234_5678, 32'h8765_4378, 32'h1234_5678,
                                 32'h8765_4378, 32'h0000_0000, 32'hFFFF_FFFF,
                                 32'h1234_5678};
    wait_idle();
    write_reg(REG_MODE, {11'h000, MODE_RGBA});
    for (int i = 0; i < 7; i++) send_word(CMD_PIXEL, pat[i]);
    send_word(CMD_DRAIN, 32'hFFFF_FFFF);
    finish_frame();
  endtask

  // width shrunk mid-row: the next column past the new width ends the row
  task automatic test_width_shrink();
    wait_idle();
    write_reg(REG_WIDTH, 12'd4);
    write_reg(REG_MODE, {11'h2AA, MODE_BYTE});
    refresh_palette();
    for (int i = 0; i < 7; i++) send_word(CMD_PIXEL, pick_pixel());
    wait_idle();
    write_reg(REG_WIDTH, 12'd2);
    send_word(CMD_PIXEL, pick_pixel());
    finish_frame();
  endtask

  // width above the maximum acts as the maximum, a later shrink ends the row
  task automatic test_wide_width();
    wait_idle();
    write_reg(REG_WIDTH, 12'hFFF);
    write_reg(REG_MODE, {11'($urandom_range(0, 2047)), 1'($urandom_range(0, 1))});
    refresh_palette();
    for (int i = 0; i < 5; i++) send_word(CMD_PIXEL, pick_pixel());
    wait_idle();
    write_reg(REG_WIDTH, 12'd3);
    for (int i = 0; i < 7; i++) send_word(CMD_PIXEL, pick_pixel());
    finish_frame();
  endtask

  // random frames with stray drains, widths and modes change between frames
  task automatic test_random_frames();
    int unsigned rows, w;
    while (words_sent < 480) begin
      wait_idle();
      idle_en = ($urandom_range(0, 3) != 0);
      w = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 48) : $urandom_range(0, 12);
      write_reg(REG_WIDTH, CfgW'(w));
      if ($urandom_range(0, 1) == 0)
        write_reg(REG_MODE, {11'($urandom_range(0, 2047)), 1'($urandom_range(0, 1))});
      refresh_palette();
      rows = $urandom_range(1, 6);
      for (int i = 0; i < rows * active_width(); i++) begin
        if ($urandom_range(0, 19) == 0) send_stray_drain();
        else send_word(CMD_PIXEL, pick_pixel());
      end
      if ($urandom_range(0, 3) == 0) begin
        wait_idle();
        send_stray_drain();
      end
      finish_frame();
    end
    idle_en = 1'b1;
  endtask

  // closing frame with words back to back and the receiver never stalled
  task automatic test_back_to_back();
    wait_idle();
    idle_en = 1'b0;
    write_reg(REG_WIDTH, 12'd6);
    write_reg(REG_MODE, {11'($urandom_range(0, 2047)), 1'($urandom_range(0, 1))});
    refresh_palette();
    for (int i = 0; i < 24; i++) send_word(CMD_PIXEL, pick_pixel());
    finish_frame();
  endtask

  initial begin
    refresh_palette();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_reset_defaults();
    test_width_zero();
    test_byte_mode();
    test_rgba_drain_mid_row();
    test_width_shrink();
    test_wide_width();
    test_random_frames();
    test_back_to_back();
    wait_idle();
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
